// ===== rtl/core/madb_pkg.sv =====
`timescale 1ns / 1ps
package madb_pkg;

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int LEVEL_W  = 16;
  localparam int INDEX_W  = 16;

  // Internal widths
  localparam int SUM_W   = 24;   // running sum of roots, Q16.8
  localparam int SQ_W    = 25;   // a*a + b*b
  localparam int ROOT_W  = 21;   // floor(sqrt((a*a + b*b) * 2^16))
  localparam int RAD_W   = 42;   // radicand, padded to an even bit count
  localparam int REM_W   = 23;   // root remainder
  localparam int PC_W    = 3;    // pair counter
  localparam int CNT_W   = 5;    // step counter of the root unit

  // Serial step counts
  localparam int SQ_STEPS = SAMPLE_W;
  localparam int RT_STEPS = RAD_W / 2;

  // Digit-serial multiplier: 31-bit multiplicand times 8-bit digits
  localparam int MCAND_W    = 31;
  localparam int DIG_W      = 8;
  localparam int MUL_DIGITS = 4;
  localparam int MPLIER_W   = DIG_W * MUL_DIGITS;
  localparam int ACC_W      = MCAND_W + DIG_W + 1;
  localparam int FRAC_W     = 24;
  localparam int MSB_W      = 5;
  localparam int LOG_ROUNDS = FRAC_W;

  // dB scaling: T = log2 * DB_PER_LOG2 + DB_OFFSET * 2^24
  localparam longint DB_PER_LOG2 = 64'sd101008905;
  localparam longint DB_OFFSET   = -64'sd999999500;

  localparam int BLOCK_LEN_DEF = 5;

  localparam logic signed [LEVEL_W-1:0] LEVEL_FLOOR = 16'sh8000;
  localparam logic signed [LEVEL_W-1:0] LEVEL_MAX   = 16'sh7FFF;
  localparam logic signed [LEVEL_W-1:0] LEVEL_MIN   = 16'sh8001;

  // Status of a serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // log2 in Q8.24, evaluated at elaboration only
  function automatic longint log2_q24_const(input int unsigned x);
    longint unsigned y;
    longint unsigned frac;
    int m;
    m    = 0;
    frac = 0;
    if (x == 0) begin
      return 0;
    end
    for (int i = 0; i < 31; i++) begin
      if (((x >> i) & 1) != 0) begin
        m = i;
      end
    end
    y = longint'(x) << (30 - m);
    for (int i = 23; i >= 0; i--) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        y = y >> 1;
        frac = frac | (64'd1 << i);
      end
    end
    return longint'((longint'(m) << 24) | frac);
  endfunction

endpackage

// ===== rtl/core/madb_in_if.sv =====
`timescale 1ns / 1ps
interface madb_in_if;
  logic                            valid;
  logic                            ready;
  logic [madb_pkg::SAMPLE_W-1:0]   sample_a;
  logic [madb_pkg::SAMPLE_W-1:0]   sample_b;

  modport source (output valid, output sample_a, output sample_b, input ready);
  modport sink   (input valid, input sample_a, input sample_b, output ready);
endinterface

// ===== rtl/core/madb_out_if.sv =====
`timescale 1ns / 1ps
interface madb_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [madb_pkg::LEVEL_W-1:0]  level_db;
  logic [madb_pkg::INDEX_W-1:0]         result_index;

  modport source (output valid, output level_db, output result_index, input ready);
  modport sink   (input valid, input level_db, input result_index, output ready);
endinterface

// ===== rtl/core/magnitude_average_to_db.sv =====
`timescale 1ns / 1ps
// Mean IQ magnitude in dB.
// in_ch carries one pair of 12-bit ADC codes per beat (valid/ready). out_ch
// carries one result every BLOCK_LEN pairs: level_db (signed Q8.8, -32768 for
// a zero sum) and a wrapping 16-bit result_index.
// One pair is worked at a time. in_ch.ready drops with a beat and rises again
// once the pair is done: bit-serial squaring, a one-bit-per-cycle restoring
// root and a step to fold the root into the sum, so no new pair is taken
// before the last one is folded in. The last pair of a block also runs the log
// unit: normalizing shifts, 24 squaring rounds on an 8-bit-digit multiplier,
// scaling and rounding, and then the result is posted. out_ch.valid and
// in_ch.ready rise together; a zero sum skips the log unit.
// The output register parts the two sides: new pairs are taken while a
// result waits, and only a block end that finds the previous result still
// untaken waits for out_ch.ready.
// A synchronous reset (rst_n low) clears the sum, the pair count and the
// result index, and drops any pending result.
module magnitude_average_to_db #(
  parameter int BLOCK_LEN = madb_pkg::BLOCK_LEN_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  madb_in_if.sink  in_ch,
  madb_out_if.source out_ch
);
  import madb_pkg::*;

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_SQRT = 2'd1;
  localparam logic [1:0] T_LOG  = 2'd2;
  localparam logic [1:0] T_OUT  = 2'd3;

  logic [1:0]                 st_r, st_nxt;
  logic [PC_W-1:0]            pc_r, pc_nxt;
  logic [SUM_W-1:0]           sum_r, sum_nxt;
  logic [INDEX_W-1:0]         idx_r, idx_nxt;
  logic signed [LEVEL_W-1:0]  lvl_r, lvl_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [LEVEL_W-1:0]  out_level_r, out_level_nxt;
  logic [INDEX_W-1:0]         out_index_r, out_index_nxt;

  logic                       in_beat;
  logic                       out_load;
  logic                       log_start;
  unit_stat_t                 sq_stat;
  unit_stat_t                 log_stat;
  logic [ROOT_W-1:0]          root;
  logic signed [LEVEL_W-1:0]  log_level;
  logic [SUM_W-1:0]           sum_add;
  logic [PC_W:0]              cnt;

  assign in_ch.ready = (st_r == T_IDLE);
  assign in_beat     = in_ch.valid && in_ch.ready;
  assign out_load    = (st_r == T_OUT) && (!out_valid_r || out_ch.ready);

  assign sum_add = sum_r + SUM_W'(root);
  assign cnt     = {1'b0, pc_r} + (PC_W + 1)'(1);

  madb_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_beat),
    .a     (in_ch.sample_a),
    .b     (in_ch.sample_b),
    .stat  (sq_stat),
    .root  (root)
  );

  madb_log #(
    .BLOCK_LEN (BLOCK_LEN)
  ) u_log (
    .clk   (clk),
    .rst_n (rst_n),
    .start (log_start),
    .sum   (sum_add),
    .stat  (log_stat),
    .level (log_level)
  );

  // Sequence one pair, close a block, post the result
  always_comb begin
    st_nxt    = st_r;
    pc_nxt    = pc_r;
    sum_nxt   = sum_r;
    idx_nxt   = idx_r;
    lvl_nxt   = lvl_r;
    log_start = 1'b0;
    case (st_r)
      T_IDLE: begin
        if (in_beat) begin
          st_nxt = T_SQRT;
        end
      end
      T_SQRT: begin
        if (sq_stat.done) begin
          if (cnt < (PC_W + 1)'(BLOCK_LEN)) begin
            sum_nxt = sum_add;
            pc_nxt  = cnt[PC_W-1:0];
            st_nxt  = T_IDLE;
          end else begin
            sum_nxt = '0;
            pc_nxt  = '0;
            if (sum_add == '0) begin
              lvl_nxt = LEVEL_FLOOR;
              st_nxt  = T_OUT;
            end else begin
              log_start = 1'b1;
              st_nxt    = T_LOG;
            end
          end
        end
      end
      T_LOG: begin
        if (log_stat.done) begin
          lvl_nxt = log_level;
          st_nxt  = T_OUT;
        end
      end
      T_OUT: begin
        if (out_load) begin
          idx_nxt = idx_r + INDEX_W'(1);
          st_nxt  = T_IDLE;
        end
      end
      default: begin
        st_nxt = T_IDLE;
      end
    endcase
  end

  // Hold the result until the sink takes the beat
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_level_nxt = out_level_r;
    out_index_nxt = out_index_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_level_nxt = lvl_r;
      out_index_nxt = idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_IDLE;
      pc_r        <= '0;
      sum_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      pc_r        <= pc_nxt;
      sum_r       <= sum_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lvl_r       <= lvl_nxt;
    out_level_r <= out_level_nxt;
    out_index_r <= out_index_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.level_db     = out_level_r;
  assign out_ch.result_index = out_index_r;

  // Neither serial unit may still run while a new pair is taken
  a_idle_units : assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (!sq_stat.busy && !log_stat.busy))
    else $error("serial unit busy while input is ready");

  // Root completes only while the sequencer waits for it
  a_sqrt_done : assert property (@(posedge clk) disable iff (!rst_n)
    sq_stat.done |-> (st_r == T_SQRT))
    else $error("root done outside of root wait");

  // Log completes only while the sequencer waits for it
  a_log_done : assert property (@(posedge clk) disable iff (!rst_n)
    log_stat.done |-> (st_r == T_LOG))
    else $error("log done outside of log wait");

  // A posted result carries the index before the increment
  a_post_index : assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && (out_index_r == $past(idx_r))
                  && (idx_r == $past(idx_r) + INDEX_W'(1))))
    else $error("result index not posted correctly");

  // Pair count stays inside the block
  a_pc_range : assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, pc_r} < (PC_W + 1)'(BLOCK_LEN)))
    else $error("pair count out of range");

endmodule

// ===== rtl/core/madb_sqrt.sv =====
`timescale 1ns / 1ps
module madb_sqrt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [madb_pkg::SAMPLE_W-1:0]   a,
  input  logic [madb_pkg::SAMPLE_W-1:0]   b,
  output madb_pkg::unit_stat_t            stat,
  output logic [madb_pkg::ROOT_W-1:0]     root
);
  import madb_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SQ   = 2'd1;
  localparam logic [1:0] S_RT   = 2'd2;

  localparam int MC_W = 2 * SAMPLE_W;

  logic [1:0]          ph_r, ph_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                done_r, done_nxt;
  logic [MC_W-1:0]     ma_r, ma_nxt, mb_r, mb_nxt;
  logic [SAMPLE_W-1:0] ba_r, ba_nxt, bb_r, bb_nxt;
  logic [SQ_W-1:0]     sq_r, sq_nxt;
  logic [RAD_W-1:0]    rad_r, rad_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [ROOT_W-1:0]   q_r, q_nxt;

  logic [SQ_W-1:0]     sq_add;
  logic [REM_W+1:0]    trial_rem;
  logic [REM_W+1:0]    trial_sub;

  // Shift-add step of both squares, one multiplier bit each
  assign sq_add = sq_r + (ba_r[0] ? SQ_W'(ma_r) : '0) + (bb_r[0] ? SQ_W'(mb_r) : '0);

  // Restoring root step: bring down two radicand bits, try to subtract 4q+1
  assign trial_rem = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial_sub = {2'b00, q_r, 2'b01};

  always_comb begin
    ph_nxt   = ph_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    ma_nxt   = ma_r;
    mb_nxt   = mb_r;
    ba_nxt   = ba_r;
    bb_nxt   = bb_r;
    sq_nxt   = sq_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    case (ph_r)
      S_IDLE: begin
        if (start) begin
          ma_nxt  = MC_W'(a);
          mb_nxt  = MC_W'(b);
          ba_nxt  = a;
          bb_nxt  = b;
          sq_nxt  = '0;
          cnt_nxt = '0;
          ph_nxt  = S_SQ;
        end
      end
      S_SQ: begin
        sq_nxt  = sq_add;
        ma_nxt  = {ma_r[MC_W-2:0], 1'b0};
        mb_nxt  = {mb_r[MC_W-2:0], 1'b0};
        ba_nxt  = {1'b0, ba_r[SAMPLE_W-1:1]};
        bb_nxt  = {1'b0, bb_r[SAMPLE_W-1:1]};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(SQ_STEPS - 1)) begin
          rad_nxt = {1'b0, sq_add, 16'b0};
          rem_nxt = '0;
          q_nxt   = '0;
          cnt_nxt = '0;
          ph_nxt  = S_RT;
        end
      end
      S_RT: begin
        rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
        if (trial_rem >= trial_sub) begin
          rem_nxt = REM_W'(trial_rem - trial_sub);
          q_nxt   = {q_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial_rem[REM_W-1:0];
          q_nxt   = {q_r[ROOT_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(RT_STEPS - 1)) begin
          done_nxt = 1'b1;
          ph_nxt   = S_IDLE;
        end
      end
      default: begin
        ph_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= S_IDLE;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    ma_r  <= ma_nxt;
    mb_r  <= mb_nxt;
    ba_r  <= ba_nxt;
    bb_r  <= bb_nxt;
    sq_r  <= sq_nxt;
    rad_r <= rad_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign stat.busy = (ph_r != S_IDLE);
  assign stat.done = done_r;
  assign root      = q_r;

endmodule

// ===== rtl/core/madb_log.sv =====
`timescale 1ns / 1ps
module madb_log #(
  parameter int BLOCK_LEN = madb_pkg::BLOCK_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [madb_pkg::SUM_W-1:0]          sum,
  output madb_pkg::unit_stat_t                stat,
  output logic signed [madb_pkg::LEVEL_W-1:0] level
);
  import madb_pkg::*;

  localparam logic [2:0] L_IDLE  = 3'd0;
  localparam logic [2:0] L_NORM  = 3'd1;
  localparam logic [2:0] L_LOG   = 3'd2;
  localparam logic [2:0] L_SCALE = 3'd3;
  localparam logic [2:0] L_ROUND = 3'd4;

  localparam int DIGC_W = $clog2(MUL_DIGITS);
  localparam int RND_W  = $clog2(LOG_ROUNDS);

  // Fold log2(BLOCK_LEN), the Q.8 point and the volt offset into one constant,
  // plus half an output LSB for round to nearest.
  localparam longint LOG_CORR = log2_q24_const(BLOCK_LEN) + (64'sd8 <<< 24);
  localparam longint T0_L     = DB_OFFSET * 64'sd16777216 - LOG_CORR * DB_PER_LOG2
                                + (64'sd1 <<< 39);
  localparam logic signed [63:0] T0 = 64'(T0_L);
  localparam logic [MCAND_W-1:0] K_MCAND = MCAND_W'(DB_PER_LOG2);

  logic [2:0]              st_r, st_nxt;
  logic                    done_r, done_nxt;
  logic [MCAND_W-1:0]      y_r, y_nxt;
  logic [MSB_W-1:0]        msb_r, msb_nxt;
  logic [FRAC_W-1:0]       frac_r, frac_nxt;
  logic [MPLIER_W-1:0]     yd_r, yd_nxt;
  logic [31:0]             hi_r, hi_nxt, lo_r, lo_nxt;
  logic [DIGC_W-1:0]       dig_r, dig_nxt;
  logic [RND_W-1:0]        rnd_r, rnd_nxt;
  logic signed [LEVEL_W-1:0] level_r, level_nxt;

  logic [MCAND_W-1:0]      mcand;
  logic [ACC_W-1:0]        mul_sum;
  logic [63:0]             prod_full;
  logic [31:0]             sq_top;
  logic [MCAND_W-1:0]      y_sq;
  logic [FRAC_W-1:0]       frac_sh;
  logic signed [63:0]      t_sum;
  logic signed [23:0]      q_raw;
  logic                    last_dig;

  // One digit of the shared multiplier: partial product plus upper accumulator
  assign mcand    = (st_r == L_SCALE) ? K_MCAND : y_r;
  assign mul_sum  = {8'b0, hi_r} + ACC_W'(mcand) * ACC_W'(yd_r[DIG_W-1:0]);
  assign last_dig = (dig_r == DIGC_W'(MUL_DIGITS - 1));

  // Square finished on the last digit: keep bits 61..30, renormalize
  assign prod_full = {mul_sum, lo_r[31:DIG_W]};
  assign sq_top    = prod_full[61:30];
  assign y_sq      = sq_top[31] ? sq_top[31:1] : sq_top[30:0];
  assign frac_sh   = {frac_r[FRAC_W-2:0], sq_top[31]};

  // Offset, round and take the Q8.8 dB level
  assign t_sum = $signed({hi_r, lo_r}) + T0;
  assign q_raw = t_sum[63:40];

  always_comb begin
    st_nxt    = st_r;
    done_nxt  = 1'b0;
    y_nxt     = y_r;
    msb_nxt   = msb_r;
    frac_nxt  = frac_r;
    yd_nxt    = yd_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    dig_nxt   = dig_r;
    rnd_nxt   = rnd_r;
    level_nxt = level_r;
    case (st_r)
      L_IDLE: begin
        if (start) begin
          y_nxt   = {sum, 7'b0};
          msb_nxt = MSB_W'(SUM_W - 1);
          st_nxt  = L_NORM;
        end
      end
      L_NORM: begin
        // shift up until the leading one sits at bit 30
        if (y_r[MCAND_W-1]) begin
          yd_nxt  = MPLIER_W'(y_r);
          hi_nxt  = '0;
          lo_nxt  = '0;
          dig_nxt = '0;
          rnd_nxt = '0;
          st_nxt  = L_LOG;
        end else begin
          y_nxt   = {y_r[MCAND_W-2:0], 1'b0};
          msb_nxt = msb_r - MSB_W'(1);
        end
      end
      L_LOG: begin
        if (!last_dig) begin
          hi_nxt  = mul_sum[ACC_W-1:DIG_W];
          lo_nxt  = {mul_sum[DIG_W-1:0], lo_r[31:DIG_W]};
          yd_nxt  = {{DIG_W{1'b0}}, yd_r[MPLIER_W-1:DIG_W]};
          dig_nxt = dig_r + DIGC_W'(1);
        end else begin
          y_nxt    = y_sq;
          frac_nxt = frac_sh;
          yd_nxt   = MPLIER_W'(y_sq);
          hi_nxt   = '0;
          lo_nxt   = '0;
          dig_nxt  = '0;
          rnd_nxt  = rnd_r + RND_W'(1);
          if (rnd_r == RND_W'(LOG_ROUNDS - 1)) begin
            yd_nxt = {3'b0, msb_r, frac_sh};
            st_nxt = L_SCALE;
          end
        end
      end
      L_SCALE: begin
        hi_nxt  = mul_sum[ACC_W-1:DIG_W];
        lo_nxt  = {mul_sum[DIG_W-1:0], lo_r[31:DIG_W]};
        yd_nxt  = {{DIG_W{1'b0}}, yd_r[MPLIER_W-1:DIG_W]};
        dig_nxt = dig_r + DIGC_W'(1);
        if (last_dig) begin
          st_nxt = L_ROUND;
        end
      end
      L_ROUND: begin
        if (q_raw > 24'(LEVEL_MAX)) begin
          level_nxt = LEVEL_MAX;
        end else if (q_raw < 24'(LEVEL_MIN)) begin
          level_nxt = LEVEL_MIN;
        end else begin
          level_nxt = q_raw[LEVEL_W-1:0];
        end
        done_nxt = 1'b1;
        st_nxt   = L_IDLE;
      end
      default: begin
        st_nxt = L_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= L_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    y_r     <= y_nxt;
    msb_r   <= msb_nxt;
    frac_r  <= frac_nxt;
    yd_r    <= yd_nxt;
    hi_r    <= hi_nxt;
    lo_r    <= lo_nxt;
    dig_r   <= dig_nxt;
    rnd_r   <= rnd_nxt;
    level_r <= level_nxt;
  end

  assign stat.busy = (st_r != L_IDLE);
  assign stat.done = done_r;
  assign level     = level_r;

endmodule
